[hdl/masked_tile_blit_page_framebuffer_macros.svh]
// Assertion macros for the masked tile blit framebuffer.
// Used by the top level; expects clk and rst_n in scope.
`ifndef MASKED_TILE_BLIT_PAGE_FRAMEBUFFER_MACROS_SVH
`define MASKED_TILE_BLIT_PAGE_FRAMEBUFFER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MTB_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MTB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/mtb_pkg.sv]
// Shared types and constants for the masked tile blit framebuffer.
// No dependencies; used by mtb_frame_ram and the top level.
`default_nettype none

package mtb_pkg;

    localparam int SCREEN_W    = 128;
    localparam int SCREEN_H    = 64;
    localparam int PAGES       = (SCREEN_H + 7) / 8;
    localparam int STORE_BYTES = SCREEN_W * PAGES;
    localparam int ADDR_W      = $clog2(STORE_BYTES);

    localparam logic MODE_DRAW = 1'b0;
    localparam logic MODE_READ = 1'b1;

    // Eight columns times two page halves.
    localparam logic [3:0] LAST_STEP = 4'd15;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_MERGE,
        ST_RDCAP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              en;
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } ram_req_t;

endpackage

`default_nettype wire

[hdl/mtb_req_if.sv]
// Request channel for the masked tile blit framebuffer.
// Carries draw and read items; no dependencies.
`default_nettype none

interface mtb_req_if;
    logic              valid;
    logic              ready;
    logic              mode;
    logic [63:0]       tile_bits;
    logic [63:0]       mask_bits;
    logic signed [8:0] pos_x;
    logic signed [8:0] pos_y;
    logic [9:0]        read_index;

    modport source (output valid, mode, tile_bits, mask_bits, pos_x, pos_y, read_index,
                    input ready);
    modport sink (input valid, mode, tile_bits, mask_bits, pos_x, pos_y, read_index,
                  output ready);
endinterface

`default_nettype wire

[hdl/mtb_rsp_if.sv]
// Result channel for the masked tile blit framebuffer.
// Carries one result item per request; no dependencies.
`default_nettype none

interface mtb_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       drawn;

    modport source (output valid, read_data, drawn, input ready);
    modport sink (input valid, read_data, drawn, output ready);
endinterface

`default_nettype wire

[hdl/mtb_frame_ram.sv]
// Single-port framebuffer memory with registered read data.
// Depends on mtb_pkg for the depth and the request struct.
`default_nettype none

module mtb_frame_ram (
    input  wire logic              clk,
    input  wire mtb_pkg::ram_req_t ram_req,
    output logic [7:0]             rdata
);

    logic [7:0] mem [mtb_pkg::STORE_BYTES];

    always_ff @(posedge clk)
    begin
        if (ram_req.en && ram_req.we)
        begin
            mem[ram_req.addr] <= ram_req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_req.en && !ram_req.we)
        begin
            rdata <= mem[ram_req.addr];
        end
    end

endmodule

`default_nettype wire

[hdl/mtb_merge.sv]
// Shared shift-and-merge unit: places one tile column byte at a vertical
// offset into either the upper or the lower page byte. Depends on nothing.
`default_nettype none

module mtb_merge (
    input  wire logic [7:0] old_byte,
    input  wire logic [7:0] tile_byte,
    input  wire logic [7:0] mask_byte,
    input  wire logic [2:0] off,
    input  wire logic       half,
    output logic [7:0]      new_byte
);

    logic [23:0] keep_win;
    logic [15:0] set_win;

    // The ones padding on both sides keeps rows outside the tile untouched.
    always_comb
    begin
        keep_win = {8'hff, mask_byte, 8'hff} << off;
        set_win  = {8'h00, tile_byte} << off;
        if (half)
        begin
            new_byte = (old_byte & keep_win[23:16]) | set_win[15:8];
        end
        else
        begin
            new_byte = (old_byte & keep_win[15:8]) | set_win[7:0];
        end
    end

endmodule

`default_nettype wire

[hdl/masked_tile_blit_page_framebuffer.sv]
// Masked tile blit into a page-mode monochrome framebuffer.
//
// Channel req takes draw items (mode 0: 8x8 tile, mask, signed position) and
// read items (mode 1: one byte at read_index). Channel rsp returns one item
// per request: read_data for reads (zero for draws, and for an index beyond
// the store), drawn for draws that wrote at least one byte.
// After reset a clearing pass writes zero to all 1024 bytes, one per cycle;
// req.ready stays low until the pass is done.
// A read issues the memory read on acceptance, captures the byte in RDCAP and
// loads the result register in DONE. A draw walks 16 slots (8 columns, upper
// and lower page): SCAN skips an off-screen slot; a visible one is read there
// and written in MERGE via the single port; a wholly off-screen tile goes to DONE.
// The block works on one item at a time; req.ready is high only when idle.
// The result register holds a finished item while rsp.ready is low, and the
// next item may be accepted meanwhile; it waits at its end until the register
// is free.
// Depends on mtb_pkg, mtb_req_if, mtb_rsp_if, mtb_frame_ram, mtb_merge and
// the assertion macro header.
`default_nettype none
`include "masked_tile_blit_page_framebuffer_macros.svh"

module masked_tile_blit_page_framebuffer (
    input  wire logic clk,
    input  wire logic rst_n,
    mtb_req_if.sink   req,
    mtb_rsp_if.source rsp
);

    mtb_pkg::state_t state_reg, state_next;
    logic [mtb_pkg::ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic [3:0]        step_reg, step_next;
    logic              rsp_valid_reg, rsp_valid_next;

    logic [63:0]       tile_reg, tile_next;
    logic [63:0]       mask_reg, mask_next;
    logic signed [8:0] x_reg, x_next;
    logic signed [5:0] page_reg, page_next;
    logic [2:0]        off_reg, off_next;
    logic              idx_ok_reg, idx_ok_next;
    logic [7:0]        data_reg, data_next;
    logic              drawn_reg, drawn_next;
    logic [7:0]        rsp_data_reg, rsp_data_next;
    logic              rsp_drawn_reg, rsp_drawn_next;

    mtb_pkg::ram_req_t ram_req;
    logic [7:0]        ram_rdata;

    logic signed [9:0] col;
    logic signed [6:0] page_cur;
    logic              slot_vis;
    logic              onscreen;
    logic [mtb_pkg::ADDR_W-1:0] slot_addr;
    logic [7:0]        tile_byte;
    logic [7:0]        mask_byte;
    logic [7:0]        merged;

    mtb_frame_ram u_ram (
        .clk     (clk),
        .ram_req (ram_req),
        .rdata   (ram_rdata)
    );

    mtb_merge u_merge (
        .old_byte  (ram_rdata),
        .tile_byte (tile_byte),
        .mask_byte (mask_byte),
        .off       (off_reg),
        .half      (step_reg[0]),
        .new_byte  (merged)
    );

    // Current slot: column step[3:1], lower page when step[0] is set.
    always_comb
    begin
        col       = {x_reg[8], x_reg} + 10'(step_reg[3:1]);
        page_cur  = {page_reg[5], page_reg} + 7'(step_reg[0]);
        tile_byte = tile_reg[step_reg[3:1]*8 +: 8];
        mask_byte = mask_reg[step_reg[3:1]*8 +: 8];
        slot_vis  = (int'(col) >= 0) && (int'(col) < mtb_pkg::SCREEN_W)
                    && (int'(page_cur) >= 0) && (int'(page_cur) < mtb_pkg::PAGES)
                    && (!step_reg[0] || (off_reg != 3'd0));
        slot_addr = mtb_pkg::ADDR_W'(int'(page_cur) * mtb_pkg::SCREEN_W + int'(col));
        onscreen  = (int'(req.pos_x) >= -7) && (int'(req.pos_x) < mtb_pkg::SCREEN_W)
                    && (int'(req.pos_y) >= -7) && (int'(req.pos_y) < mtb_pkg::SCREEN_H);
    end

    assign req.ready     = (state_reg == mtb_pkg::ST_IDLE);
    assign rsp.valid     = rsp_valid_reg;
    assign rsp.read_data = rsp_data_reg;
    assign rsp.drawn     = rsp_drawn_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        step_next      = step_reg;
        rsp_valid_next = rsp_valid_reg;
        tile_next      = tile_reg;
        mask_next      = mask_reg;
        x_next         = x_reg;
        page_next      = page_reg;
        off_next       = off_reg;
        idx_ok_next    = idx_ok_reg;
        data_next      = data_reg;
        drawn_next     = drawn_reg;
        rsp_data_next  = rsp_data_reg;
        rsp_drawn_next = rsp_drawn_reg;
        ram_req        = '0;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            mtb_pkg::ST_CLEAR:
            begin
                ram_req.en   = 1'b1;
                ram_req.we   = 1'b1;
                ram_req.addr = clr_addr_reg;
                if (clr_addr_reg == mtb_pkg::ADDR_W'(mtb_pkg::STORE_BYTES - 1))
                begin
                    state_next = mtb_pkg::ST_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end
            mtb_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.mode == mtb_pkg::MODE_READ)
                    begin
                        ram_req.en   = 1'b1;
                        ram_req.addr = mtb_pkg::ADDR_W'(req.read_index);
                        idx_ok_next  = int'(req.read_index) < mtb_pkg::STORE_BYTES;
                        drawn_next   = 1'b0;
                        state_next   = mtb_pkg::ST_RDCAP;
                    end
                    else
                    begin
                        tile_next  = req.tile_bits;
                        mask_next  = req.mask_bits;
                        x_next     = req.pos_x;
                        page_next  = 6'(req.pos_y >>> 3);
                        off_next   = req.pos_y[2:0];
                        step_next  = '0;
                        data_next  = '0;
                        drawn_next = 1'b0;
                        state_next = onscreen ? mtb_pkg::ST_SCAN : mtb_pkg::ST_DONE;
                    end
                end
            end
            mtb_pkg::ST_RDCAP:
            begin
                data_next  = idx_ok_reg ? ram_rdata : 8'h00;
                state_next = mtb_pkg::ST_DONE;
            end
            mtb_pkg::ST_SCAN:
            begin
                if (slot_vis)
                begin
                    ram_req.en   = 1'b1;
                    ram_req.addr = slot_addr;
                    state_next   = mtb_pkg::ST_MERGE;
                end
                else if (step_reg == mtb_pkg::LAST_STEP)
                begin
                    state_next = mtb_pkg::ST_DONE;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            mtb_pkg::ST_MERGE:
            begin
                ram_req.en    = 1'b1;
                ram_req.we    = 1'b1;
                ram_req.addr  = slot_addr;
                ram_req.wdata = merged;
                drawn_next    = 1'b1;
                if (step_reg == mtb_pkg::LAST_STEP)
                begin
                    state_next = mtb_pkg::ST_DONE;
                end
                else
                begin
                    step_next  = step_reg + 1'b1;
                    state_next = mtb_pkg::ST_SCAN;
                end
            end
            mtb_pkg::ST_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_data_next  = data_reg;
                    rsp_drawn_next = drawn_reg;
                    state_next     = mtb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mtb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mtb_pkg::ST_CLEAR;
            clr_addr_reg  <= '0;
            step_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            step_reg      <= step_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tile_reg      <= tile_next;
        mask_reg      <= mask_next;
        x_reg         <= x_next;
        page_reg      <= page_next;
        off_reg       <= off_next;
        idx_ok_reg    <= idx_ok_next;
        data_reg      <= data_next;
        drawn_reg     <= drawn_next;
        rsp_data_reg  <= rsp_data_next;
        rsp_drawn_reg <= rsp_drawn_next;
    end

    `MTB_ASSERT_SAME(a_write_states, ram_req.en && ram_req.we,
        (state_reg == mtb_pkg::ST_CLEAR) || (state_reg == mtb_pkg::ST_MERGE),
        "framebuffer written outside the clear pass or a merge")
    `MTB_ASSERT_SAME(a_merge_addr, state_reg == mtb_pkg::ST_MERGE,
        ram_req.addr == $past(ram_req.addr), "merge writes a byte it did not read")
    `MTB_ASSERT_NEXT(a_merge_once, state_reg == mtb_pkg::ST_MERGE,
        state_reg != mtb_pkg::ST_MERGE, "two merges without a read between them")
    `MTB_ASSERT_SAME(a_result_load, $rose(rsp_valid_reg),
        $past(state_reg) == mtb_pkg::ST_DONE, "result item loaded outside the done state")

endmodule

`default_nettype wire
